// ----- rtl/core/cfbh_pkg.sv -----
`default_nettype none

package cfbh_pkg;

  // Histogram geometry
  localparam int NUM_BINS = 256;
  localparam int BIN_BITS = 8;

  // Case folding of ASCII capitals
  localparam logic [BIN_BITS-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [BIN_BITS-1:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [BIN_BITS-1:0] CASE_OFFSET   = 8'h20;

  // Operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;

  // One classified beat: operation and the bin it touches
  typedef struct packed {
    logic                op;
    logic [BIN_BITS-1:0] bin;
  } item_t;

  // Back-end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DIVIDE
  } back_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/case_folded_byte_histogram.sv -----
// Channel   Ports                                              Handshake
// input     in_op, in_byte_value, in_bin_index                 start high, busy low
// result    out_bin_count, out_total_count, out_frequency      out_valid, one cycle
//
// The front end takes a beat whenever the two-entry queue has room.
// The back end handles an add as a bin read, then increment and write,
// and a read through the one-bit-per-cycle restoring divider that forms
// the share.
// Synchronous active-low reset clears every bin through per-bin valid
// bits at once; no clearing pass is needed. Results cannot be stalled.
`default_nettype none

module case_folded_byte_histogram #(
  parameter int COUNT_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_op,
  input  wire logic [cfbh_pkg::BIN_BITS-1:0] in_byte_value,
  input  wire logic [cfbh_pkg::BIN_BITS-1:0] in_bin_index,
  output logic                               out_valid,
  output logic [COUNT_BITS-1:0]              out_bin_count,
  output logic [COUNT_BITS-1:0]              out_total_count,
  output logic [FRAC_BITS:0]                 out_frequency
);

  cfbh_pkg::item_t push_item;
  cfbh_pkg::item_t head_item;
  logic            push, pop, empty, full;

  // Accept and classify
  cfbh_front u_front (
    .start         (start),
    .in_op         (in_op),
    .in_byte_value (in_byte_value),
    .in_bin_index  (in_bin_index),
    .queue_full    (full),
    .busy          (busy),
    .push          (push),
    .item          (push_item)
  );

  // Decouple front and back
  cfbh_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .empty     (empty),
    .full      (full)
  );

  // Count and report
  cfbh_back #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_item       (head_item),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_bin_count   (out_bin_count),
    .out_total_count (out_total_count),
    .out_frequency   (out_frequency)
  );

  // A read passes through the lookup and divide states, so strobes never touch
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in consecutive cycles");

  // A bin can never hold more than the total
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bin_count <= out_total_count))
    else $error("bin count above total");

  // Share stays within 1.0
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frequency <= ((FRAC_BITS+1)'(1) << FRAC_BITS)))
    else $error("share above one");

  // Empty histogram reports zero share
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_total_count == '0)) |-> (out_frequency == '0))
    else $error("nonzero share with empty total");

endmodule

`default_nettype wire

// ----- rtl/core/cfbh_front.sv -----
`default_nettype none

module cfbh_front (
  input  wire logic                          start,
  input  wire logic                          in_op,
  input  wire logic [cfbh_pkg::BIN_BITS-1:0] in_byte_value,
  input  wire logic [cfbh_pkg::BIN_BITS-1:0] in_bin_index,
  input  wire logic                          queue_full,
  output logic                               busy,
  output logic                               push,
  output cfbh_pkg::item_t                    item
);

  logic                          is_upper;
  logic [cfbh_pkg::BIN_BITS-1:0] folded;

  // Fold ASCII capitals onto lower case
  always_comb begin
    is_upper = (in_byte_value >= cfbh_pkg::ASCII_UPPER_A) &&
               (in_byte_value <= cfbh_pkg::ASCII_UPPER_Z);
    folded   = is_upper ? (in_byte_value + cfbh_pkg::CASE_OFFSET) : in_byte_value;
  end

  // Classify the beat and pick the bin it addresses
  always_comb begin
    item.op  = in_op;
    item.bin = (in_op == cfbh_pkg::OP_ADD) ? folded : in_bin_index;
  end

  // Accept while the queue has room
  assign busy = queue_full;
  assign push = start && !queue_full;

endmodule

`default_nettype wire

// ----- rtl/core/cfbh_queue.sv -----
`default_nettype none

module cfbh_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire cfbh_pkg::item_t push_item,
  input  wire logic            pop,
  output cfbh_pkg::item_t      head_item,
  output logic                 empty,
  output logic                 full
);

  cfbh_pkg::item_t                     slot_r [cfbh_pkg::QUEUE_DEPTH];
  logic [cfbh_pkg::QPTR_BITS-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [cfbh_pkg::QPTR_BITS-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [cfbh_pkg::QPTR_BITS:0]        count_r, count_nxt;
  logic                                do_push, do_pop;

  assign empty     = (count_r == '0);
  assign full      = (count_r == (cfbh_pkg::QPTR_BITS+1)'(cfbh_pkg::QUEUE_DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = slot_r[rd_ptr_r];

  // Advance pointers with wrap and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == (cfbh_pkg::QPTR_BITS)'(cfbh_pkg::QUEUE_DEPTH-1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == (cfbh_pkg::QPTR_BITS)'(cfbh_pkg::QUEUE_DEPTH-1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold payload in the slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cfbh_back.sv -----
`default_nettype none

module cfbh_back #(
  parameter int COUNT_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cfbh_pkg::item_t        head_item,
  input  wire logic                   empty,
  output logic                        pop,
  output logic                        out_valid,
  output logic [COUNT_BITS-1:0]       out_bin_count,
  output logic [COUNT_BITS-1:0]       out_total_count,
  output logic [FRAC_BITS:0]          out_frequency
);

  localparam int STEP_BITS = $clog2(FRAC_BITS + 1);

  typedef struct packed {
    logic pop;
    logic bin_we;
    logic load_div;
    logic div_step;
    logic emit;
  } ctrl_t;

  cfbh_pkg::back_state_t state_r, state_nxt;
  ctrl_t                 ctrl;

  logic [COUNT_BITS-1:0]         bin_mem [cfbh_pkg::NUM_BINS];
  logic [cfbh_pkg::NUM_BINS-1:0] valid_r;
  logic [COUNT_BITS-1:0]         rd_data_r;
  logic                          hit_r;
  cfbh_pkg::item_t               cur_r;
  logic [COUNT_BITS-1:0]         total_r;
  logic [COUNT_BITS-1:0]         cnt_r;
  logic [COUNT_BITS-1:0]         den_r;
  logic [COUNT_BITS-1:0]         rem_r, rem_nxt;
  logic [FRAC_BITS:0]            quot_r, quot_nxt;
  logic [STEP_BITS-1:0]          step_r;

  logic                          out_valid_r;
  logic [COUNT_BITS-1:0]         out_cnt_r, out_tot_r;
  logic [FRAC_BITS:0]            out_freq_r;

  logic [COUNT_BITS-1:0]         cnt;
  logic [COUNT_BITS-1:0]         cnt_inc;
  logic [COUNT_BITS-1:0]         total_inc;
  logic                          first_ge;
  logic [COUNT_BITS-1:0]         first_rem;
  logic [COUNT_BITS:0]           shifted;
  logic [COUNT_BITS:0]           den_ext;
  logic                          step_ge;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfbh_pkg::ST_IDLE: begin
        if (!empty) begin
          state_nxt = cfbh_pkg::ST_LOOKUP;
        end
      end
      cfbh_pkg::ST_LOOKUP: begin
        state_nxt = (cur_r.op == cfbh_pkg::OP_ADD) ? cfbh_pkg::ST_IDLE :
                                                     cfbh_pkg::ST_DIVIDE;
      end
      cfbh_pkg::ST_DIVIDE: begin
        if (step_r == '0) begin
          state_nxt = cfbh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cfbh_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl = '0;
    unique case (state_r)
      cfbh_pkg::ST_IDLE: begin
        ctrl.pop = !empty;
      end
      cfbh_pkg::ST_LOOKUP: begin
        ctrl.bin_we   = (cur_r.op == cfbh_pkg::OP_ADD);
        ctrl.load_div = (cur_r.op == cfbh_pkg::OP_READ);
      end
      cfbh_pkg::ST_DIVIDE: begin
        ctrl.div_step = (step_r != '0);
        ctrl.emit     = (step_r == '0);
      end
      default: ctrl = '0;
    endcase
  end

  assign pop = ctrl.pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfbh_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Bin store: write after increment, registered read at the queue head
  always_ff @(posedge clk) begin
    if (ctrl.bin_we) begin
      bin_mem[cur_r.bin] <= cnt_inc;
    end
    rd_data_r <= bin_mem[head_item.bin];
  end

  // Bins never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (ctrl.bin_we) begin
        valid_r[cur_r.bin] <= 1'b1;
      end
      hit_r <= valid_r[head_item.bin];
    end
  end

  // Saturating increments and first division step
  always_comb begin
    cnt       = hit_r ? rd_data_r : '0;
    cnt_inc   = (cnt == '1) ? cnt : cnt + 1'b1;
    total_inc = (total_r == '1) ? total_r : total_r + 1'b1;
    first_ge  = (cnt >= total_r);
    first_rem = first_ge ? (cnt - total_r) : cnt;
  end

  // One restoring division step per cycle
  always_comb begin
    shifted  = {rem_r, 1'b0};
    den_ext  = {1'b0, den_r};
    step_ge  = (shifted >= den_ext);
    rem_nxt  = step_ge ? COUNT_BITS'(shifted - den_ext) : COUNT_BITS'(shifted);
    quot_nxt = {quot_r[FRAC_BITS-1:0], step_ge};
  end

  // Running total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (ctrl.bin_we) begin
      total_r <= total_inc;
    end
  end

  // Latch the popped beat
  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      cur_r <= head_item;
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (ctrl.load_div) begin
      cnt_r  <= cnt;
      den_r  <= total_r;
      rem_r  <= first_rem;
      quot_r <= {{FRAC_BITS{1'b0}}, first_ge};
      step_r <= STEP_BITS'(FRAC_BITS);
    end else if (ctrl.div_step) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
      step_r <= step_r - 1'b1;
    end
  end

  // Result strobe for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_cnt_r  <= cnt_r;
      out_tot_r  <= den_r;
      out_freq_r <= (den_r == '0) ? '0 : quot_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_count   = out_cnt_r;
  assign out_total_count = out_tot_r;
  assign out_frequency   = out_freq_r;

endmodule

`default_nettype wire
